/* design/strict_decimal_to_int32_parser_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the strict decimal parser unit
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef STRICT_DECIMAL_TO_INT32_PARSER_UNIT_ASSERT_SVH
`define STRICT_DECIMAL_TO_INT32_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define SDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sdp_pkg.sv */
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared constants, status codes and types of the strict decimal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sdp_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int OUT_BITS       = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic    negative;
    logic    sign_seen;
    logic    digit_seen;
    status_t err;
  } flags_t;

  typedef struct packed {
    logic       valid;
    logic       eos;
    logic [7:0] char_code;
  } req_t;

endpackage

`default_nettype wire

/* design/sdp_in_reg.sv */
// ----------------------------------------------------------------------------
// sdp_in_reg
// Input register stage: captures one request per cycle, holds it when stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_char_code,
  input  logic          in_end_of_string,
  output logic          in_stall,
  input  logic          advance,
  output sdp_pkg::req_t req
);
  import sdp_pkg::*;

  logic       valid_r, valid_nxt;
  logic       eos_r;
  logic [7:0] char_r;

  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      eos_r  <= in_end_of_string;
      char_r <= in_char_code;
    end
  end

  assign req.valid     = valid_r;
  assign req.eos       = eos_r;
  assign req.char_code = char_r;

endmodule

`default_nettype wire

/* design/sdp_parse_core.sv */
// ----------------------------------------------------------------------------
// sdp_parse_core
// Parse state and single-step update: sign, digit accumulate, range check.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_parse_core #(
  parameter int VALUE_BITS = sdp_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  sdp_pkg::req_t                         req,
  output logic signed [sdp_pkg::OUT_BITS-1:0]   res_value,
  output sdp_pkg::status_t                      res_status
);
  import sdp_pkg::*;

  localparam int EXT = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  flags_t                flags_r, flags_nxt;

  logic                  is_digit, is_sign;
  logic [3:0]            digit;
  logic [EXT-1:0]        acc_ext, sum, limit;
  logic                  ovf;
  logic [VALUE_BITS-1:0] signed_val;
  logic [OUT_BITS-1:0]   out_val;

  assign is_digit = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
  assign is_sign  = (req.char_code == CH_PLUS) || (req.char_code == CH_MINUS);
  assign digit    = 4'(req.char_code - CH_ZERO);
  assign acc_ext  = EXT'(acc_r);
  assign sum      = (acc_ext << 3) + (acc_ext << 1) + EXT'(digit);
  assign limit    = (EXT'(1) << (VALUE_BITS - 1)) - EXT'(!flags_r.negative);
  assign ovf      = sum > limit;

  always_comb begin
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    if (take) begin
      if (req.eos) begin
        acc_nxt   = '0;
        flags_nxt = '{negative: 1'b0, sign_seen: 1'b0, digit_seen: 1'b0, err: ST_OK};
      end else if (flags_r.err == ST_OK) begin
        if (is_sign) begin
          if (flags_r.sign_seen || flags_r.digit_seen) begin
            flags_nxt.err = ST_FORMAT;
          end else begin
            flags_nxt.sign_seen = 1'b1;
            flags_nxt.negative  = (req.char_code == CH_MINUS);
          end
        end else if (is_digit) begin
          flags_nxt.digit_seen = 1'b1;
          if (ovf) begin
            flags_nxt.err = ST_OVERFLOW;
          end else begin
            acc_nxt = sum[VALUE_BITS-1:0];
          end
        end else begin
          flags_nxt.err = ST_FORMAT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      flags_r <= '{negative: 1'b0, sign_seen: 1'b0, digit_seen: 1'b0, err: ST_OK};
    end else begin
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign signed_val = flags_r.negative ? (~acc_r + 1'b1) : acc_r;

  generate
    if (VALUE_BITS >= OUT_BITS) begin : g_trunc
      assign out_val = signed_val[OUT_BITS-1:0];
    end else begin : g_sext
      assign out_val = {{(OUT_BITS-VALUE_BITS){signed_val[VALUE_BITS-1]}}, signed_val};
    end
  endgenerate

  always_comb begin
    res_status = flags_r.err;
    if (flags_r.err == ST_OK && !flags_r.digit_seen) begin
      res_status = ST_FORMAT;
    end
    res_value = (res_status == ST_OK) ? signed'(out_val) : '0;
  end

endmodule

`default_nettype wire

/* design/sdp_out_reg.sv */
// ----------------------------------------------------------------------------
// sdp_out_reg
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic signed [sdp_pkg::OUT_BITS-1:0] res_value,
  input  sdp_pkg::status_t                    res_status,
  output logic                                out_free,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [sdp_pkg::OUT_BITS-1:0] out_value,
  output logic [1:0]                          out_status
);
  import sdp_pkg::*;

  logic                       valid_r, valid_nxt;
  logic signed [OUT_BITS-1:0] value_r;
  status_t                    status_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (out_free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= res_value;
      status_r <= res_status;
    end
  end

  assign out_valid  = valid_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

/* design/strict_decimal_to_int32_parser_unit.sv */
// ----------------------------------------------------------------------------
// strict_decimal_to_int32_parser_unit
// Streaming strict decimal text to signed integer parser.
// ----------------------------------------------------------------------------
// Takes one request per cycle: a text byte, or a terminator. Bytes build a
// signed value (one leading sign, then decimal digits, checked against the
// signed VALUE_BITS range); the terminator returns the value and a status
// (ok, format error, overflow; first error wins, value 0 on error) and clears
// the parse state. Throughput is one request per clock unless a terminator
// waits on a stalled result; the multiply-by-ten, add and limit compare that
// update the accumulator are combinational. A result is loaded into the result
// register from the input register and held there until taken. While an earlier
// result is still stalled, a terminator waits in the input register and the input stalls behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_decimal_to_int32_parser_unit #(
  parameter int VALUE_BITS = sdp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_end_of_string,
  output logic                                in_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sdp_pkg::OUT_BITS-1:0] out_value,
  output logic [1:0]                          out_status
);
  import sdp_pkg::*;

  req_t                       req;
  logic                       advance, load, out_free;
  logic signed [OUT_BITS-1:0] res_value;
  status_t                    res_status;

  // advance characters freely; a terminator waits for room in the result register
  assign advance = req.valid && (!req.eos || out_free);
  assign load    = advance && req.eos;

  sdp_in_reg u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .in_stall         (in_stall),
    .advance          (advance),
    .req              (req)
  );

  sdp_parse_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (advance),
    .req        (req),
    .res_value  (res_value),
    .res_status (res_status)
  );

  sdp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res_value  (res_value),
    .res_status (res_status),
    .out_free   (out_free),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

`default_nettype wire

/* design/sdp_checker.sv */
// ----------------------------------------------------------------------------
// sdp_checker
// Port-level checks of the strict decimal parser unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "strict_decimal_to_int32_parser_unit_assert.svh"

module sdp_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                in_end_of_string,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [sdp_pkg::OUT_BITS-1:0] out_value,
  input wire logic [1:0]                          out_status
);
  import sdp_pkg::*;

  `SDP_ASSERT_NOW(a_err_value_zero,
    out_valid && out_status != ST_OK, out_value == '0,
    "error result with non-zero value")
  `SDP_ASSERT_NOW(a_no_stall_when_empty,
    !out_valid, !in_stall,
    "input stalled with empty result register")
  `SDP_ASSERT_NOW(a_result_from_terminator,
    $rose(out_valid), $past(in_valid && !in_stall && in_end_of_string, 2),
    "result without accepted terminator")
  `SDP_ASSERT_NEXT(a_result_hold,
    out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status),
    "stalled result changed")

endmodule

bind strict_decimal_to_int32_parser_unit sdp_checker u_sdp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_end_of_string (in_end_of_string),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_value        (out_value),
  .out_status       (out_status)
);

`default_nettype wire

/* sim/strict_decimal_to_int32_parser_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_decimal_to_int32_parser_unit_tb
// Streams text bytes and terminators into the parser and checks each
// returned value and status against an in-bench model of the parse state.
// Both channels idle and stall at random, apart from one stretch at full rate.
// ----------------------------------------------------------------------------
module strict_decimal_to_int32_parser_unit_tb;
  import sdp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic signed [31:0] value;
    status_t            status;
  } parse_result_t;

  typedef logic [7:0] text_t[$];

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic [7:0]          in_char_code = 8'h00;
  logic                in_end_of_string = 1'b0;
  logic                out_stall = 1'b0;
  wire                 in_stall;
  wire                 out_valid;
  wire signed [31:0]   out_value;
  wire [1:0]           out_status;

  parse_result_t expected_parses[$];
  int            mismatch_count = 0;
  int            items_sent = 0;
  int            cycle_count = 0;
  bit            idle_en = 1'b1;

  logic [31:0] mag_acc;
  logic        neg_flag;
  logic        sign_flag;
  logic        digit_flag;
  status_t     first_err;

  always #5 clk = ~clk;

  strict_decimal_to_int32_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_status       (out_status)
  );

  function automatic void clear_parse();
    mag_acc    = '0;
    neg_flag   = 1'b0;
    sign_flag  = 1'b0;
    digit_flag = 1'b0;
    first_err  = ST_OK;
  endfunction

  function automatic void absorb_byte(logic [7:0] ch);
    longint unsigned grown;
    longint unsigned limit;
    if (first_err != ST_OK) return;
    if (ch == CH_MINUS || ch == CH_PLUS) begin
      if (sign_flag || digit_flag) begin
        first_err = ST_FORMAT;
      end else begin
        if (ch == CH_MINUS) neg_flag = 1'b1;
        sign_flag = 1'b1;
      end
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      digit_flag = 1'b1;
      limit = neg_flag ? 64'd2147483648 : 64'd2147483647;
      grown = longint'(mag_acc) * 10 + longint'(ch - CH_ZERO);
      if (grown > limit) first_err = ST_OVERFLOW;
      else mag_acc = grown[31:0];
    end else begin
      first_err = ST_FORMAT;
    end
  endfunction

  function automatic parse_result_t close_string();
    parse_result_t r;
    r.status = first_err;
    if (r.status == ST_OK && !digit_flag) r.status = ST_FORMAT;
    r.value = '0;
    if (r.status == ST_OK) r.value = neg_flag ? -mag_acc : mag_acc;
    clear_parse();
    return r;
  endfunction

  function automatic text_t to_text(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Send one request; returns at the edge where it is taken, valid still high
  task automatic send_item(logic [7:0] ch, logic eos);
    while (idle_en && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      in_char_code <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= ch;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (eos) expected_parses.push_back(close_string());
    else absorb_byte(ch);
  endtask

  task automatic send_string(text_t t);
    foreach (t[i]) send_item(t[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_most_negative();
    send_string(to_text("-2147483648"));
  endtask

  task automatic test_malformed();
    text_t t;
    send_string(t);
    send_string(to_text("+"));
    send_string(to_text("+-"));
    send_string(to_text("7+"));
    t = {8'hFF, CH_ZERO + 8'd5};
    send_string(t);
  endtask

  function automatic text_t number_text();
    longint unsigned mag;
    string           s;
    int              sign_kind;
    sign_kind = $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: mag = $urandom_range(0, 999);
      1: mag = 64'd2147483645 + $urandom_range(0, 6);
      2: mag = $urandom;
      default: mag = longint'($urandom) * 1000 + $urandom_range(0, 999);
    endcase
    s = $sformatf("%0d", mag);
    if ($urandom_range(0, 3) == 0) begin
      s = {"00", s};
      s = s.substr($urandom_range(0, 2), s.len() - 1);
    end
    if (sign_kind == 1) s = {"+", s};
    else if (sign_kind == 2) s = {"-", s};
    return to_text(s);
  endfunction

  task automatic test_random_strings();
    text_t t;
    int    first_item;
    int    kind;
    int    len;
    first_item = items_sent;
    idle_en = 1'b0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (items_sent - first_item >= CALM_ITEMS) idle_en = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        t = number_text();
      end else if (kind < 80) begin
        t = number_text();
        t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        t.delete();
        len = $urandom_range(0, 6);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: t.push_back(CH_PLUS);
            1: t.push_back(CH_MINUS);
            2: t.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            default: t.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      send_string(t);
    end
  endtask

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_parses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value %0d status %0d", out_value, out_status);
      end else begin
        want = expected_parses.pop_front();
        if (out_value !== want.value || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                     want.value, out_value, want.status, out_status);
        end
      end
    end
    out_stall <= rst_n && idle_en && ($urandom_range(0, 99) < 26);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_parse();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_most_negative();
    test_malformed();
    test_random_strings();
    in_valid <= 1'b0;
    while (expected_parses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
